// ----- src/tksmh_pkg.sv -----
// package for the top-k smallest max-heap unit: state type, data width, keep-count width and reset value
`timescale 1ns / 1ps

package tksmh_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned KEEP_W = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage

// ----- src/tksmh_ram.sv -----
// heap store: one write port, two registered read ports
`timescale 1ns / 1ps

module tksmh_ram
  import tksmh_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/top_k_smallest_max_heap_unit.sv -----
// top-k smallest values of a signed stream kept in a max-heap
// insert: the new sample sifts up from the end of the heap, one level per parent read and compare
// replace: a sample below the root replaces it and sifts down; any other sample is dropped
// emission: held entries are sent one at a time, paced by the single output register
// all work goes through one heap ram with two read ports and one write port
// synchronous active-low reset empties the heap and sets keep_count to 16
`timescale 1ns / 1ps

module top_k_smallest_max_heap_unit
  import tksmh_pkg::*;
#(
  parameter int unsigned MAX_KEEP = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     in_end_of_stream,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_kept_value,
  output logic                     out_final_of_run,
  output logic                     out_short_stream,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [KEEP_W-1:0]        cfg_keep_count
);

  localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned CW = $clog2(MAX_KEEP + 1);

  state_t state_r, state_nxt;

  logic [KEEP_W-1:0]        keep_count_r;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic                     last_r, last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_final_r, out_final_nxt;
  logic                     out_short_r, out_short_nxt;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr_a;
  logic [AW-1:0]            mem_raddr_b;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;

  logic [CW-1:0]            eff_k;
  logic                     in_xfer;
  logic                     do_insert;
  logic [AW-1:0]            parent;
  logic [CW:0]              child_l;
  logic [CW:0]              child_r;
  logic                     l_in;
  logic                     r_in;
  logic                     v_gt_a;
  logic                     a_gt_v;
  logic                     r_gt;
  logic signed [DATA_W-1:0] big_val;
  logic                     emit_last;
  state_t                   done_state;

  tksmh_ram #(
    .DEPTH (MAX_KEEP),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != S_IDLE);
  assign in_xfer          = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_kept_value   = out_value_r;
  assign out_final_of_run = out_final_r;
  assign out_short_stream = out_short_r;

  // effective k: zero reads as one, clamped to the heap depth
  always_comb begin
    if (keep_count_r == '0) begin
      eff_k = CW'(1);
    end else if (32'(keep_count_r) > MAX_KEEP) begin
      eff_k = CW'(MAX_KEEP);
    end else begin
      eff_k = CW'(keep_count_r);
    end
  end

  // shared compare and index unit
  always_comb begin
    do_insert  = (fill_r < eff_k) && (32'(fill_r) < MAX_KEEP);
    parent     = AW'((pos_r - AW'(1)) >> 1);
    child_l    = {(CW + 1 - AW)'(0), pos_r} * (CW + 1)'(2) + (CW + 1)'(1);
    child_r    = child_l + (CW + 1)'(1);
    l_in       = child_l < {1'b0, fill_r};
    r_in       = child_r < {1'b0, fill_r};
    v_gt_a     = v_r > rd_a;
    a_gt_v     = rd_a > v_r;
    big_val    = a_gt_v ? rd_a : v_r;
    r_gt       = r_in && (rd_b > big_val);
    emit_last  = (CW'(idx_r) + CW'(1)) == fill_r;
    done_state = last_r ? S_EMIT_RD : S_IDLE;
  end

  // next state and datapath registers
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_short_nxt = out_short_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          v_nxt    = in_sample;
          last_nxt = in_end_of_stream;
          idx_nxt  = '0;
          if (do_insert) begin
            pos_nxt   = AW'(fill_r);
            fill_nxt  = fill_r + CW'(1);
            state_nxt = S_UP_RD;
          end else if (fill_r != '0) begin
            state_nxt = S_ROOT_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (pos_r == '0) ? done_state : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (v_gt_a) begin
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = done_state;
        end
      end
      S_ROOT_RD: begin
        state_nxt = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        if (a_gt_v) begin
          pos_nxt   = '0;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = done_state;
        end
      end
      S_DN_RD: begin
        state_nxt = l_in ? S_DN_CMP : done_state;
      end
      S_DN_CMP: begin
        if (r_gt) begin
          pos_nxt   = child_r[AW-1:0];
          state_nxt = S_DN_RD;
        end else if (a_gt_v) begin
          pos_nxt   = child_l[AW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = done_state;
        end
      end
      S_EMIT_RD: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_a;
        out_final_nxt = emit_last;
        out_short_nxt = fill_r < eff_k;
        if (emit_last) begin
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // heap ram control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = v_r;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    unique case (state_r)
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr_a = parent;
        end
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = v_gt_a ? rd_a : v_r;
      end
      S_DN_RD: begin
        if (l_in) begin
          mem_raddr_a = child_l[AW-1:0];
          mem_raddr_b = child_r[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (r_gt) begin
          mem_wdata = rd_b;
        end else if (a_gt_v) begin
          mem_wdata = rd_a;
        end else begin
          mem_wdata = v_r;
        end
      end
      S_EMIT_RD: begin
        mem_raddr_a = idx_r;
      end
      S_IDLE, S_ROOT_RD, S_ROOT_CMP, S_EMIT_LD: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      keep_count_r <= KEEP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_count_r <= cfg_keep_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    v_r         <= v_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_short_r <= out_short_nxt;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_KEEP)
    else $error("heap fill exceeds depth");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while a sample is in work");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD) |-> !out_valid_r)
    else $error("output register overwritten");

  a_sink_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_RD) |-> (CW'(pos_r) < fill_r))
    else $error("sift-down position outside heap");
`endif

endmodule
